// ----- hdl/rdca_pkg.sv -----
// Shared types and constants for the region density averager.
// Request, result and queue-entry structs, field widths and code constants.
// No dependencies.
package rdca_pkg;

  localparam int unsigned MaxBases  = 1024;
  localparam int unsigned BaseW     = 11;
  localparam int unsigned PctW      = 7;
  localparam int unsigned ReadsW    = 24;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = 32;
  localparam int unsigned CntW      = 16;
  localparam int unsigned MeanW     = 22;
  localparam int unsigned UcntMeanW = 6;
  localparam int unsigned ProdW     = 31;
  localparam int unsigned QuoW      = 34;
  localparam int unsigned DivW      = BaseW + 1;
  localparam int unsigned StepCntW  = $clog2(QuoW);

  localparam logic [1:0] ZygNone = 2'd0;
  localparam logic [1:0] ZygHet  = 2'd1;
  localparam logic [1:0] ZygHom  = 2'd2;

  localparam logic ReqHeader = 1'b0;
  localparam logic ReqSample = 1'b1;

  localparam logic CfgHetLow = 1'b0;
  localparam logic CfgHom    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [BaseW-1:0]   base_count;
    logic [ReadsW-1:0]  variant_reads;
    logic [ReadsW-1:0]  depth_reads;
    logic [SampleW-1:0] read_sample;
    logic [SampleW-1:0] repeat_sample;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [1:0]           zygosity;
    logic [MeanW-1:0]     mean_read_density;
    logic [MeanW-1:0]     mean_repeat_density;
    logic [UcntMeanW-1:0] mean_uncovered_count;
    logic [MeanW-1:0]     mean_uncovered_repeat;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       zygosity;
    logic [BaseW-1:0] bases;
    logic [SumW-1:0]  read_sum;
    logic [SumW-1:0]  repeat_sum;
    logic [CntW-1:0]  uncovered_count;
    logic [SumW-1:0]  uncovered_sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hdl/rdca_front.sv -----
// Front end: accepts words, multiplies header thresholds, classifies zygosity
// and accumulates the density sums; pushes one job per region end.
// Depends on rdca_pkg.
module rdca_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rdca_pkg::req_t       in_data_i,
  input  logic [6:0]           het_low_pct_i,
  input  logic [6:0]           hom_pct_i,
  input  rdca_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output rdca_pkg::job_t       job_o
);
  import rdca_pkg::*;

  logic             s1_valid_q;
  req_t             s1_req_q;
  logic [ProdW-1:0] s1_scaled_q;
  logic [ProdW-1:0] s1_het_q;
  logic [ProdW-1:0] s1_hom_q;

  logic [SumW-1:0]  read_sum_q, read_sum_d;
  logic [SumW-1:0]  repeat_sum_q, repeat_sum_d;
  logic [CntW-1:0]  ucnt_q, ucnt_d;
  logic [SumW-1:0]  usum_q, usum_d;
  logic [BaseW-1:0] bases_q, bases_d;
  logic [1:0]       zyg_q, zyg_d;

  logic             is_last;
  logic             advance;
  logic             take;
  logic [SumW:0]    read_add, repeat_add, usum_add;
  logic [CntW:0]    ucnt_add;
  logic             uncovered;

  assign is_last    = s1_valid_q && (s1_req_q.req_type == ReqSample) && s1_req_q.last;
  assign advance    = s1_valid_q && !(is_last && q_status_i.full);
  assign in_stall_o = s1_valid_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Threshold products are formed on capture; compare happens on commit.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_req_q    <= in_data_i;
      s1_scaled_q <= ProdW'(in_data_i.variant_reads) * ProdW'(100);
      s1_het_q    <= ProdW'(het_low_pct_i) * ProdW'(in_data_i.depth_reads);
      s1_hom_q    <= ProdW'(hom_pct_i) * ProdW'(in_data_i.depth_reads);
    end
  end

  always_comb begin
    uncovered  = (s1_req_q.read_sample == '0) && (s1_req_q.repeat_sample != '0);
    read_add   = {1'b0, read_sum_q} + (SumW + 1)'(s1_req_q.read_sample);
    repeat_add = {1'b0, repeat_sum_q} + (SumW + 1)'(s1_req_q.repeat_sample);
    usum_add   = {1'b0, usum_q} + (SumW + 1)'(s1_req_q.repeat_sample);
    ucnt_add   = {1'b0, ucnt_q} + (CntW + 1)'(1);

    read_sum_d   = read_sum_q;
    repeat_sum_d = repeat_sum_q;
    ucnt_d       = ucnt_q;
    usum_d       = usum_q;
    bases_d      = bases_q;
    zyg_d        = zyg_q;

    if (advance) begin
      if (s1_req_q.req_type == ReqHeader) begin
        bases_d = (s1_req_q.base_count > BaseW'(MaxBases)) ? BaseW'(MaxBases)
                                                             : s1_req_q.base_count;
        priority if (s1_scaled_q > s1_het_q && s1_scaled_q < s1_hom_q) begin
          zyg_d = ZygHet;
        end else if (s1_scaled_q >= s1_hom_q) begin
          zyg_d = ZygHom;
        end else begin
          zyg_d = ZygNone;
        end
        read_sum_d   = '0;
        repeat_sum_d = '0;
        ucnt_d       = '0;
        usum_d       = '0;
      end else begin
        // saturate on carry out
        read_sum_d   = read_add[SumW] ? '1 : read_add[SumW-1:0];
        repeat_sum_d = repeat_add[SumW] ? '1 : repeat_add[SumW-1:0];
        if (uncovered) begin
          ucnt_d = ucnt_add[CntW] ? '1 : ucnt_add[CntW-1:0];
          usum_d = usum_add[SumW] ? '1 : usum_add[SumW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_sum_q   <= '0;
      repeat_sum_q <= '0;
      ucnt_q       <= '0;
      usum_q       <= '0;
      bases_q      <= '0;
      zyg_q        <= ZygNone;
    end else begin
      read_sum_q   <= read_sum_d;
      repeat_sum_q <= repeat_sum_d;
      ucnt_q       <= ucnt_d;
      usum_q       <= usum_d;
      bases_q      <= bases_d;
      zyg_q        <= zyg_d;
    end
  end

  assign push_o = advance && is_last;

  always_comb begin
    job_o.zygosity        = zyg_q;
    job_o.bases           = bases_q;
    job_o.read_sum        = read_sum_d;
    job_o.repeat_sum      = repeat_sum_d;
    job_o.uncovered_count = ucnt_d;
    job_o.uncovered_sum   = usum_d;
  end

endmodule

// ----- hdl/rdca_queue.sv -----
// Small job queue between the accumulating front and the dividing back end.
// Depends on rdca_pkg.
module rdca_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rdca_pkg::job_t      job_i,
  input  logic                pop_i,
  output rdca_pkg::job_t      job_o,
  output rdca_pkg::q_status_t status_o
);
  import rdca_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + FillW'(1);
      2'b01:   fill_d = fill_q - FillW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (fill_q == FillW'(Depth));
  assign status_o.empty = (fill_q == '0);

endmodule

// ----- hdl/rdca_div_lane.sv -----
// One radix-2 restoring divider lane: floor((2*sum + n) / (2*n)).
// One quotient bit per step. Depends on rdca_pkg.
module rdca_div_lane (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic [rdca_pkg::SumW-1:0]    sum_i,
  input  logic [rdca_pkg::BaseW-1:0]   bases_i,
  output logic [rdca_pkg::QuoW-1:0]    quo_o
);
  import rdca_pkg::*;

  logic [QuoW-1:0] quo_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] div_q;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[QuoW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= QuoW'({sum_i, 1'b0}) + QuoW'(bases_i);
      rem_q <= '0;
      div_q <= {bases_i, 1'b0};
    end else if (step_i) begin
      // shift dividend out, quotient bits in
      quo_q <= {quo_q[QuoW-2:0], ge};
      rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
    end
  end

  assign quo_o = quo_q;

endmodule

// ----- hdl/rdca_back.sv -----
// Back end: pops a region job, runs four divider lanes in parallel and holds
// the rounded, saturated means until the receiver takes them.
// Depends on rdca_pkg and rdca_div_lane.
module rdca_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdca_pkg::q_status_t q_status_i,
  input  rdca_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdca_pkg::rsp_t      out_data_o
);
  import rdca_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e              state_q;
  logic [StepCntW-1:0] step_q;
  logic                out_valid_q;
  logic [1:0]          zyg_q;
  logic [BaseW-1:0]    bases_q;
  logic                step;
  logic [QuoW-1:0]     quo_read, quo_repeat, quo_ucnt, quo_usum;

  assign pop_o = (state_q == StIdle) && !q_status_i.empty;
  assign step  = (state_q == StDiv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (!q_status_i.empty) begin
            state_q <= StDiv;
            step_q  <= '0;
          end
        end
        StDiv: begin
          step_q <= step_q + StepCntW'(1);
          if (step_q == StepCntW'(QuoW - 1)) begin
            state_q     <= StDone;
            out_valid_q <= 1'b1;
          end
        end
        StDone: begin
          if (!out_stall_i) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zyg_q   <= job_i.zygosity;
      bases_q <= job_i.bases;
    end
  end

  rdca_div_lane u_lane_read (
    .clk_i  (clk_i),
    .load_i (pop_o),
    .step_i (step),
    .sum_i  (job_i.read_sum),
    .bases_i(job_i.bases),
    .quo_o  (quo_read)
  );

  rdca_div_lane u_lane_repeat (
    .clk_i  (clk_i),
    .load_i (pop_o),
    .step_i (step),
    .sum_i  (job_i.repeat_sum),
    .bases_i(job_i.bases),
    .quo_o  (quo_repeat)
  );

  rdca_div_lane u_lane_ucnt (
    .clk_i  (clk_i),
    .load_i (pop_o),
    .step_i (step),
    .sum_i  (SumW'(job_i.uncovered_count)),
    .bases_i(job_i.bases),
    .quo_o  (quo_ucnt)
  );

  rdca_div_lane u_lane_usum (
    .clk_i  (clk_i),
    .load_i (pop_o),
    .step_i (step),
    .sum_i  (job_i.uncovered_sum),
    .bases_i(job_i.bases),
    .quo_o  (quo_usum)
  );

  // Empty region reports zero means; wide quotients clamp to all ones.
  always_comb begin
    out_data_o.zygosity = zyg_q;
    if (bases_q == '0) begin
      out_data_o.mean_read_density     = '0;
      out_data_o.mean_repeat_density   = '0;
      out_data_o.mean_uncovered_count  = '0;
      out_data_o.mean_uncovered_repeat = '0;
    end else begin
      out_data_o.mean_read_density     = (|quo_read[QuoW-1:MeanW]) ? '1
                                                                    : quo_read[MeanW-1:0];
      out_data_o.mean_repeat_density   = (|quo_repeat[QuoW-1:MeanW]) ? '1
                                                                      : quo_repeat[MeanW-1:0];
      out_data_o.mean_uncovered_count  = (|quo_ucnt[QuoW-1:UcntMeanW]) ? '1
                                                                        : quo_ucnt[UcntMeanW-1:0];
      out_data_o.mean_uncovered_repeat = (|quo_usum[QuoW-1:MeanW]) ? '1
                                                                    : quo_usum[MeanW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/region_density_cnv_averager_core.sv -----
// Region density averager, top level.
// Input channel (in_valid_i / in_stall_o / in_data_i): a header word opens a
// region (base count, variant reads, depth); sample words carry one read and
// one repeat density each, the final one flagged by last. Headers give no
// result. A last sample gives one result word on the output channel
// (out_valid_o / out_stall_i / out_data_o): held zygosity and four rounded
// means over the base count.
// The front takes one input word per cycle while the input is not stalled.
// It registers each accepted word and commits it from that register; a region
// end then waits in a job queue of QUEUE_DEPTH entries for the back end, whose
// four divider lanes produce one quotient bit each per step. The back end pops
// a new job only after the receiver has taken the previous result. The input
// stalls only when a last sample finds the job queue full; a stalled output
// holds its word and the divider, and the queue absorbs further region ends
// meanwhile. Reset clears sums, base count and zygosity and reloads the
// thresholds to 30 and 76 percent. cfg_we_i writes a threshold by index;
// the user must do so only while idle, as the block does not enforce it.
// Depends on rdca_pkg, rdca_front, rdca_queue, rdca_div_lane, rdca_back.
module region_density_cnv_averager_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rdca_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rdca_pkg::rsp_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [6:0]     cfg_data_i
);
  import rdca_pkg::*;

  logic [PctW-1:0] het_low_q;
  logic [PctW-1:0] hom_q;
  logic            q_push;
  logic            q_pop;
  job_t            push_job;
  job_t            head_job;
  q_status_t       q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      het_low_q <= PctW'(30);
      hom_q     <= PctW'(76);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHetLow: het_low_q <= cfg_data_i;
        CfgHom:    hom_q     <= cfg_data_i;
        default:   hom_q     <= hom_q;
      endcase
    end
  end

  rdca_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .het_low_pct_i(het_low_q),
    .hom_pct_i    (hom_q),
    .q_status_i   (q_status),
    .push_o       (q_push),
    .job_o        (push_job)
  );

  rdca_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .status_o(q_status)
  );

  rdca_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .job_i      (head_job),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_status.full))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_status.empty))
    else $error("job popped from empty queue");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_status.full)
    else $error("input stalled with room in job queue");

  a_pop_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !out_valid_o)
    else $error("new job started while result pending");
`endif

endmodule

// ----- tb/tb_region_density_cnv_averager_core.sv -----
// Self-checking testbench for region_density_cnv_averager_core.
// Predicts zygosity and rounded density means per region and checks every result word;
// depends on rdca_pkg and the core RTL only.
module tb_region_density_cnv_averager_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rdca_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SatSamples   = 66;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  req_t       in_data;
  logic       out_valid;
  logic       out_stall;
  rsp_t       out_data;
  logic       cfg_we;
  logic       cfg_idx;
  logic [6:0] cfg_data;

  // predictor state
  logic [PctW-1:0]  thr_het;
  logic [PctW-1:0]  thr_hom;
  logic [SumW-1:0]  sum_read;
  logic [SumW-1:0]  sum_repeat;
  logic [SumW-1:0]  sum_uncov;
  logic [CntW-1:0]  cnt_uncov;
  logic [BaseW-1:0] bases;
  logic [1:0]       zyg_held;

  req_t        word_q[$];
  rsp_t        means_q[$];
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  bit          hold_req;
  bit          in_took;

  region_density_cnv_averager_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [1:0] zygosity_of(logic [ReadsW-1:0] snp, logic [ReadsW-1:0] depth);
    logic [63:0] scaled;
    logic [63:0] het_lim;
    logic [63:0] hom_lim;
    scaled  = 64'(snp) * 64'd100;
    het_lim = 64'(thr_het) * 64'(depth);
    hom_lim = 64'(thr_hom) * 64'(depth);
    if (scaled > het_lim && scaled < hom_lim) return ZygHet;
    if (scaled >= hom_lim) return ZygHom;
    return ZygNone;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] acc, logic [31:0] add, logic [31:0] cap);
    logic [32:0] s;
    s = {1'b0, acc} + {1'b0, add};
    return (s > {1'b0, cap}) ? cap : s[31:0];
  endfunction

  function automatic logic [MeanW-1:0] rounded_mean(logic [31:0] sum, logic [BaseW-1:0] n,
                                                    logic [MeanW-1:0] cap);
    logic [63:0] q;
    if (n == '0) return '0;
    q = (64'(sum) * 64'd2 + 64'(n)) / (64'(n) * 64'd2);
    return (q > 64'(cap)) ? cap : q[MeanW-1:0];
  endfunction

  task automatic accumulate_word(req_t w);
    rsp_t m;
    if (w.req_type == ReqHeader) begin
      bases      = (w.base_count > MaxBases) ? BaseW'(MaxBases) : w.base_count;
      zyg_held   = zygosity_of(w.variant_reads, w.depth_reads);
      sum_read   = '0;
      sum_repeat = '0;
      sum_uncov  = '0;
      cnt_uncov  = '0;
    end else begin
      sum_read   = sat_sum(sum_read, 32'(w.read_sample), 32'hFFFF_FFFF);
      sum_repeat = sat_sum(sum_repeat, 32'(w.repeat_sample), 32'hFFFF_FFFF);
      if (w.read_sample == '0 && w.repeat_sample != '0) begin
        cnt_uncov = 16'(sat_sum(32'(cnt_uncov), 32'd1, 32'h0000_FFFF));
        sum_uncov = sat_sum(sum_uncov, 32'(w.repeat_sample), 32'hFFFF_FFFF);
      end
      if (w.last) begin
        m.zygosity              = zyg_held;
        m.mean_read_density     = rounded_mean(sum_read, bases, '1);
        m.mean_repeat_density   = rounded_mean(sum_repeat, bases, '1);
        m.mean_uncovered_count  = UcntMeanW'(rounded_mean(32'(cnt_uncov), bases, 22'h3F));
        m.mean_uncovered_repeat = rounded_mean(sum_uncov, bases, '1);
        means_q.push_back(m);
      end
    end
  endtask

  task automatic check_result(rsp_t got);
    rsp_t exp;
    results_seen++;
    if (means_q.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      mismatches++;
      return;
    end
    exp = means_q.pop_front();
    if (got.zygosity != exp.zygosity) begin
      $error("zygosity: expected %0d, got %0d", exp.zygosity, got.zygosity);
      mismatches++;
    end
    if (got.mean_read_density != exp.mean_read_density) begin
      $error("mean_read_density: expected %0d, got %0d",
             exp.mean_read_density, got.mean_read_density);
      mismatches++;
    end
    if (got.mean_repeat_density != exp.mean_repeat_density) begin
      $error("mean_repeat_density: expected %0d, got %0d",
             exp.mean_repeat_density, got.mean_repeat_density);
      mismatches++;
    end
    if (got.mean_uncovered_count != exp.mean_uncovered_count) begin
      $error("mean_uncovered_count: expected %0d, got %0d",
             exp.mean_uncovered_count, got.mean_uncovered_count);
      mismatches++;
    end
    if (got.mean_uncovered_repeat != exp.mean_uncovered_repeat) begin
      $error("mean_uncovered_repeat: expected %0d, got %0d",
             exp.mean_uncovered_repeat, got.mean_uncovered_repeat);
      mismatches++;
    end
  endtask

  // fields a word type does not use get random content
  task automatic push_header(logic [BaseW-1:0] n, logic [ReadsW-1:0] snp,
                             logic [ReadsW-1:0] depth);
    req_t w;
    w.req_type      = ReqHeader;
    w.base_count    = n;
    w.variant_reads = snp;
    w.depth_reads   = depth;
    w.read_sample   = SampleW'($urandom);
    w.repeat_sample = SampleW'($urandom);
    w.last          = 1'($urandom_range(1));
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic push_sample(logic [SampleW-1:0] rd, logic [SampleW-1:0] rp, logic last);
    req_t w;
    w.req_type      = ReqSample;
    w.base_count    = BaseW'($urandom);
    w.variant_reads = ReadsW'($urandom);
    w.depth_reads   = ReadsW'($urandom);
    w.read_sample   = rd;
    w.repeat_sample = rp;
    w.last          = last;
    word_q.push_back(w);
    words_queued++;
  endtask

  function automatic logic [SampleW-1:0] rand_density();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // mostly well-formed regions; the rest stray samples and lone headers
  task automatic gen_regions(int unsigned n_words, int unsigned max_len);
    int unsigned      start;
    int unsigned      len;
    int unsigned      pick;
    logic [BaseW-1:0] n;
    logic [ReadsW-1:0] snp;
    logic [ReadsW-1:0] depth;
    logic [63:0]      t;
    start = words_queued;
    while (words_queued - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 82) begin
        if ($urandom_range(9) == 0) n = BaseW'($urandom);
        else n = BaseW'($urandom_range(1, 8));
        case ($urandom_range(3))
          0: begin
            depth = ReadsW'($urandom);
            snp   = ReadsW'($urandom);
          end
          1: begin
            depth = ReadsW'($urandom_range(0, 200));
            snp   = ReadsW'($urandom_range(0, 200));
          end
          default: begin
            // land next to a threshold
            depth = ReadsW'($urandom);
            t     = 64'(depth) * 64'(($urandom_range(1) != 0) ? thr_het : thr_hom) / 64'd100;
            snp   = t[ReadsW-1:0] + ReadsW'($urandom_range(2)) - ReadsW'(1);
          end
        endcase
        push_header(n, snp, depth);
        len = $urandom_range(1, max_len);
        for (int unsigned i = 0; i < len; i++)
          push_sample(rand_density(), rand_density(), i == len - 1);
      end else if (pick < 92) begin
        push_sample(rand_density(), rand_density(), 1'($urandom_range(1)));
      end else begin
        push_header(BaseW'($urandom), ReadsW'($urandom), ReadsW'($urandom));
      end
    end
  endtask

  task automatic write_threshold(logic idx, logic [PctW-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgHetLow) thr_het = v;
    else thr_hom = v;
  endtask

  task automatic settle();
    while (words_taken != words_queued || means_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // feed words from the pending queue
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= word_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    in_took = in_valid && !in_stall;
    if (rst_n && in_took) begin
      accumulate_word(in_data);
      words_taken++;
    end
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[region_density_cnv_averager_core] ERROR");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgHetLow;
    cfg_data      = '0;
    thr_het       = 7'd30;
    thr_hom       = 7'd76;
    sum_read      = '0;
    sum_repeat    = '0;
    sum_uncov     = '0;
    cnt_uncov     = '0;
    bases         = '0;
    zyg_held      = ZygNone;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no idling, default thresholds
    write_threshold(CfgHetLow, 7'd30);
    write_threshold(CfgHom, 7'd76);
    push_sample(16'd5, 16'd7, 1'b1);             // no region yet: means are zero
    push_header(11'd0, 24'd1, 24'd1);            // zero base count
    push_sample(16'd9, 16'd0, 1'b1);
    push_header(11'd2047, '1, '1);               // oversized base count saturates
    push_sample('1, '1, 1'b0);
    push_sample(16'd0, '1, 1'b0);
    push_sample(16'd0, 16'd0, 1'b0);
    push_sample('1, 16'd0, 1'b1);
    push_sample(16'd3, 16'd0, 1'b1);             // keeps adding after last
    push_header(11'd1, 24'd0, 24'd0);            // zero depth reads as hom
    push_sample(16'd0, 16'd1, 1'b1);
    push_header(11'd3, 24'd50, 24'd100);
    push_sample(16'd100, 16'd200, 1'b1);
    push_header(11'd5, 24'd30, 24'd100);         // exactly on the het bound
    push_sample(16'd1, 16'd0, 1'b1);
    push_header(11'd2, 24'd76, 24'd100);         // exactly on the hom bound
    push_sample(16'd0, 16'd0, 1'b1);
    push_header(11'd4, 24'd31, 24'd100);
    push_header(11'd1, 24'd75, 24'd100);         // header replaces header
    push_sample(16'd7, 16'd7, 1'b1);
    // drive the repeat and uncovered means past their field widths, then the read mean too
    push_header(11'd1, 24'd29, 24'd100);
    for (int unsigned i = 0; i < SatSamples; i++)
      push_sample(16'd0, '1, i == SatSamples - 1);
    for (int unsigned i = 0; i < SatSamples; i++)
      push_sample('1, 16'd0, i == SatSamples - 1);
    gen_regions(190, 24);
    settle();

    // sender idles, widest het window
    send_idle_pct = 81;
    stall_pct     = 0;
    write_threshold(CfgHetLow, 7'd0);
    write_threshold(CfgHom, 7'd100);
    gen_regions(190, 24);
    settle();

    // receiver stalls, thresholds inverted so het cannot occur
    send_idle_pct = 0;
    stall_pct     = 81;
    write_threshold(CfgHetLow, 7'd100);
    write_threshold(CfgHom, 7'd0);
    gen_regions(190, 24);
    settle();

    // both idle; short regions behind a long output hold-off fill the job queue
    send_idle_pct = 26;
    stall_pct     = 26;
    write_threshold(CfgHetLow, 7'd63);
    write_threshold(CfgHom, 7'd64);
    gen_regions(180, 3);
    @(posedge clk);
    hold_req = 1'b1;
    settle();

    $display("Accepted %0d words and checked %0d result words in %0d cycles.",
             words_taken, results_seen, cycles);
    $display("Covered four threshold settings, mean saturation and a long output hold-off.");
    if (mismatches == 0) begin
      $display("[region_density_cnv_averager_core] OK");
    end else begin
      $display("[region_density_cnv_averager_core] ERROR");
    end
    $finish;
  end

endmodule
